// File: hw/rtl/mwws_pkg.sv
// Package for the mutex with waiter stack: sizes, request and status codes.
// Used by mutex_with_waiter_stack; depends on nothing else.

package mwws_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int ID_BITS    = 8;

    // Waiter count holds 0..WAIT_DEPTH; the stack index needs at least one bit.
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = ((ID_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_W  = STATUS_W + ID_BITS + 1 + ID_BITS;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED        = 3'd0,
        ST_ALREADY_OWNER  = 3'd1,
        ST_QUEUED         = 3'd2,
        ST_IDLE           = 3'd3,
        ST_HANDED         = 3'd4,
        ST_DOUBLE_RELEASE = 3'd5,
        ST_FULL           = 3'd6
    } t_status;

    typedef struct packed {
        t_id     owner_id;
        logic    owner_valid;
        t_id     woken_id;
        t_status status;
    } t_result;

endpackage

// File: hw/rtl/mutex_with_waiter_stack.sv
// Single hardware mutex with a last-in first-out stack of waiting tasks.
// Depends on mwws_pkg for sizes, codes and the result layout.

// A request is taken into an input register, evaluated against the lock
// state and the top of the waiter stack, and its result lands in an output
// register; one request can be accepted in every cycle while the result is
// not stalled. The rate is set by the single stage that reads and updates
// owner, waiter count and stack top together; the waiter stack sits in
// flip-flops. A full stack drops the acquire and reports it, and a release
// on a free lock reports a double release and changes nothing.
module mutex_with_waiter_stack (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mwws_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // requester_id
    input  logic                              s_axis_tuser,  // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status, woken_id, owner_valid, owner_id, zero padding
    output logic [mwws_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import mwws_pkg::*;

    logic     r_in_vld;
    t_op      r_in_op;
    t_id      r_in_id;
    logic     r_out_vld;
    t_result  r_out;
    logic     r_held;
    t_id      r_owner;
    t_cnt     r_count;
    t_id      r_stack [WAIT_DEPTH];

    logic     n_held;
    t_id      n_owner;
    t_cnt     n_count;
    t_result  n_out;
    logic     push;
    logic     advance;
    logic     in_take;
    logic [PTR_W-1:0] top_ptr;
    logic [PTR_W-1:0] push_ptr;

    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

    assign top_ptr  = PTR_W'(r_count - t_cnt'(1));
    assign push_ptr = PTR_W'(r_count);

    always_comb begin
        n_held            = r_held;
        n_owner           = r_owner;
        n_count           = r_count;
        push              = 1'b0;
        n_out.status      = ST_GRANTED;
        n_out.woken_id    = '0;
        if (r_in_op == OP_ACQUIRE) begin
            priority if (r_held && r_owner == r_in_id) begin
                n_out.status = ST_ALREADY_OWNER;
            end else if (!r_held) begin
                n_held       = 1'b1;
                n_owner      = r_in_id;
                n_out.status = ST_GRANTED;
            end else if (r_count == t_cnt'(WAIT_DEPTH)) begin
                n_out.status = ST_FULL;
            end else begin
                push         = 1'b1;
                n_count      = r_count + t_cnt'(1);
                n_out.status = ST_QUEUED;
            end
        end else begin
            priority if (!r_held) begin
                n_out.status = ST_DOUBLE_RELEASE;
            end else if (r_count != '0) begin
                n_count        = r_count - t_cnt'(1);
                n_owner        = r_stack[top_ptr];
                n_out.woken_id = r_stack[top_ptr];
                n_out.status   = ST_HANDED;
            end else begin
                n_held       = 1'b0;
                n_owner      = '0;
                n_out.status = ST_IDLE;
            end
        end
        n_out.owner_valid = n_held;
        n_out.owner_id    = n_held ? n_owner : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_held    <= 1'b0;
            r_owner   <= '0;
            r_count   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (r_in_vld && advance) begin
                r_held  <= n_held;
                r_owner <= n_owner;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op <= t_op'(s_axis_tuser);
            r_in_id <= s_axis_tdata[ID_BITS-1:0];
        end
        if (r_in_vld && advance) begin
            r_out <= n_out;
        end
        if (r_in_vld && advance && push) begin
            r_stack[push_ptr] <= r_in_id;
        end
    end

    // The stack never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(WAIT_DEPTH))
        else $error("waiter count beyond stack depth");

    // Tasks only wait while the lock is held.
    a_waiters_need_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> r_count == '0)
        else $error("waiters queued on a free lock");

    // Input side stalls only behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_vld && !m_axis_tready && r_in_vld))
        else $error("input stalled without a blocked result");

    // A handed-over result leaves the woken task as owner.
    a_handover_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status == ST_HANDED) |->
            (r_out.owner_valid && r_out.owner_id == r_out.woken_id))
        else $error("handover result without the woken owner");

endmodule
